/* hdl/mdfm_pkg.sv */
`default_nettype none

package mdfm_pkg;

  // Field and datapath widths
  localparam int ACT_W   = 2;
  localparam int CNT_W   = 16;
  localparam int DUTY_W  = 15;
  localparam int MINF_W  = 10;
  localparam int STAT_W  = 2;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Window and timer constants
  localparam int WINDOW_LENGTH  = 30;
  localparam int TIMER_CLOCK_HZ = 1000000;
  localparam int DUTY_FULL      = 25600;

  localparam int PTR_W   = $clog2(WINDOW_LENGTH);
  localparam int SUM_W   = $clog2(WINDOW_LENGTH * DUTY_FULL + 1);
  // Divider: 16-bit divisor, 15-bit quotient, one quotient bit per step
  localparam int DVD_W     = CNT_W + DUTY_W;
  localparam int DIV_STEPS = DUTY_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
  // Window average: sum times the rounded-up reciprocal of the window length,
  // exact over the whole sum range
  localparam int AVG_SHIFT  = 24;
  localparam int AVG_RECIP  = ((1 << AVG_SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
  localparam int RECIP_W    = $clog2(AVG_RECIP + 1);
  localparam int AVG_PROD_W = SUM_W + RECIP_W;
  // Frequency test: min_freq * period * 2 against the timer clock
  localparam int FREQ_W  = MINF_W + CNT_W + 1;

  // Configuration register reset values
  localparam logic [DUTY_W-1:0] GOOD_RESET = DUTY_W'(10240);
  localparam logic [DUTY_W-1:0] FAIL_RESET = DUTY_W'(5120);
  localparam logic [MINF_W-1:0] MINF_RESET = MINF_W'(58);

  typedef enum logic [ACT_W-1:0] {
    ACT_PERIOD = 2'd0,
    ACT_HIGH   = 2'd1,
    ACT_TICK   = 2'd2
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_GOOD    = 2'd0,
    ST_FAIL    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_GOOD = 2'd0,
    REG_FAIL = 2'd1,
    REG_MINF = 2'd2
  } reg_idx_e;

  // Microcode operations
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_UPDATE,
    OP_MUL,
    OP_DLOAD_DUTY,
    OP_DSTEP,
    OP_SAMPLE,
    OP_PUSH,
    OP_AVG_MUL,
    OP_AVG_SET,
    OP_AVG_CLR,
    OP_FREQ,
    OP_EMIT,
    OP_NOP
  } op_e;

  // Jump conditions: jump to target when true, else fall through
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_REQ,
    C_NOT_CAPTURE,
    C_DIV_BUSY,
    C_OUT_FREE
  } cond_e;

  localparam int PC_W = 4;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_IDLE       = 4'd0;
  localparam pc_t PC_UPDATE     = 4'd1;
  localparam pc_t PC_MUL        = 4'd2;
  localparam pc_t PC_DLOAD_DUTY = 4'd3;
  localparam pc_t PC_DSTEP_DUTY = 4'd4;
  localparam pc_t PC_SAMPLE     = 4'd5;
  localparam pc_t PC_PUSH       = 4'd6;
  localparam pc_t PC_AVG_MUL    = 4'd7;
  localparam pc_t PC_AVG_SET    = 4'd8;
  localparam pc_t PC_TICK       = 4'd9;
  localparam pc_t PC_FREQ       = 4'd10;
  localparam pc_t PC_EMIT       = 4'd11;
  localparam pc_t PC_EMIT_WAIT  = 4'd12;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } ucode_t;

  // Control store
  function automatic ucode_t ucode_fetch(input pc_t pc);
    ucode_t uc;
    unique case (pc)
      PC_IDLE:       uc = '{OP_IDLE,       C_NO_REQ,      PC_IDLE};
      PC_UPDATE:     uc = '{OP_UPDATE,     C_NOT_CAPTURE, PC_TICK};
      PC_MUL:        uc = '{OP_MUL,        C_NEXT,        PC_IDLE};
      PC_DLOAD_DUTY: uc = '{OP_DLOAD_DUTY, C_NEXT,        PC_IDLE};
      PC_DSTEP_DUTY: uc = '{OP_DSTEP,      C_DIV_BUSY,    PC_DSTEP_DUTY};
      PC_SAMPLE:     uc = '{OP_SAMPLE,     C_NEXT,        PC_IDLE};
      PC_PUSH:       uc = '{OP_PUSH,       C_NEXT,        PC_IDLE};
      PC_AVG_MUL:    uc = '{OP_AVG_MUL,    C_NEXT,        PC_IDLE};
      PC_AVG_SET:    uc = '{OP_AVG_SET,    C_ALWAYS,      PC_FREQ};
      PC_TICK:       uc = '{OP_AVG_CLR,    C_NEXT,        PC_IDLE};
      PC_FREQ:       uc = '{OP_FREQ,       C_NEXT,        PC_IDLE};
      PC_EMIT:       uc = '{OP_EMIT,       C_OUT_FREE,    PC_IDLE};
      PC_EMIT_WAIT:  uc = '{OP_NOP,        C_ALWAYS,      PC_EMIT};
      default:       uc = '{OP_NOP,        C_ALWAYS,      PC_IDLE};
    endcase
    return uc;
  endfunction

endpackage

`default_nettype wire

/* hdl/mdfm_in_if.sv */
`default_nettype none

interface mdfm_in_if;
  import mdfm_pkg::*;

  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [CNT_W-1:0] capture_count;

  modport source (output valid, action, capture_count, input ready);
  modport sink   (input valid, action, capture_count, output ready);
endinterface

`default_nettype wire

/* hdl/mdfm_out_if.sv */
`default_nettype none

interface mdfm_out_if;
  import mdfm_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] mains_status;
  logic [DUTY_W-1:0] average_duty;
  logic              frequency_low;

  modport source (output valid, mains_status, average_duty, frequency_low, input ready);
  modport sink   (input valid, mains_status, average_duty, frequency_low, output ready);
endinterface

`default_nettype wire

/* hdl/mains_duty_frequency_monitor_core.sv */
// Mains duty and frequency monitor.
// in_i carries timer capture requests (action, capture_count): a period
// capture, a high-time capture or a timer overflow tick. Every request
// produces exactly one result on out_o: mains status, the sliding-window
// average duty (percent, Q7.8) and the low-frequency flag.
// A capture request is accepted in the idle step; its result enters the
// output register when in_i.ready also returns, so a new capture is taken
// only once the last one is through: a 15-step restoring divider for the
// duty sample, the window update, a reciprocal multiply for the average
// over 30 samples and the frequency compare, under a microcoded sequencer.
// An overflow tick or an undefined action skips the divider and the window update.
// in_i.ready is high only in the idle step.
// The result sits in an output register; a new request is accepted while
// it waits. If the receiver stalls, the sequencer holds at its emit step
// until the register frees up.
// Thresholds and minimum frequency are set through the APB port; write
// them only while the block is idle. Reset clears the window, the stored
// counts and the average, and loads the default thresholds.
`default_nettype none

module mains_duty_frequency_monitor_core (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  mdfm_in_if.sink                       in_i,
  mdfm_out_if.source                    out_o,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [mdfm_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mdfm_pkg::DATA_W-1:0] pwdata,
  output logic      [mdfm_pkg::DATA_W-1:0] prdata,
  output logic                          pready
);
  import mdfm_pkg::*;

  // Sequencer
  pc_t    pc_q, pc_d;
  ucode_t uc;
  logic   cond_true;

  // Configuration
  logic [DUTY_W-1:0] good_q;
  logic [DUTY_W-1:0] fail_q;
  logic [MINF_W-1:0] minf_q;

  // Architectural state
  logic [ACT_W-1:0]  action_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  period_q;
  logic [CNT_W-1:0]  high_q;
  logic [SUM_W-1:0]  sum_q;
  logic [PTR_W-1:0]  ptr_q;
  logic [DUTY_W-1:0] avg_q;
  logic              low_q;
  logic [WINDOW_LENGTH-1:0] vld_q;

  // Datapath working registers
  logic [DVD_W-1:0]  prod_q;
  logic [CNT_W-1:0]  rem_q;
  logic [DUTY_W-1:0] dvd_q;
  logic [CNT_W-1:0]  dsr_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DUTY_W-1:0] sample_q;
  logic [DUTY_W-1:0] rd_q;
  logic              rd_vld_q;
  logic [AVG_PROD_W-1:0] avg_prod_q;

  // Window memory
  logic [DUTY_W-1:0] win_mem [WINDOW_LENGTH];

  // Output register
  logic              out_vld_q;
  logic [STAT_W-1:0] out_stat_q;
  logic [DUTY_W-1:0] out_avg_q;
  logic              out_low_q;

  logic              in_fire;
  logic              out_free;
  logic              emit_fire;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              q_bit;
  logic [DUTY_W-1:0] old_sample;
  logic [FREQ_W-1:0] freq_prod;
  logic              freq_low;
  status_e           status;
  logic              cfg_wr;

  // Fetch and branch
  assign uc        = ucode_fetch(pc_q);
  assign in_fire   = in_i.valid && in_i.ready;
  assign out_free  = !out_vld_q || out_o.ready;
  assign emit_fire = (uc.op == OP_EMIT) && out_free;

  always_comb begin
    unique case (uc.cond)
      C_NEXT:        cond_true = 1'b0;
      C_ALWAYS:      cond_true = 1'b1;
      C_NO_REQ:      cond_true = !in_i.valid;
      C_NOT_CAPTURE: cond_true = (action_q != ACT_PERIOD) && (action_q != ACT_HIGH);
      C_DIV_BUSY:    cond_true = (cnt_q != DCNT_W'(1));
      C_OUT_FREE:    cond_true = out_free;
      default:       cond_true = 1'b0;
    endcase
    pc_d = cond_true ? uc.target : pc_q + PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign in_i.ready = (uc.op == OP_IDLE);

  // Restoring divider step: one quotient bit per cycle
  assign trial   = {rem_q, dvd_q[DUTY_W-1]};
  assign diff    = trial - {1'b0, dsr_q};
  assign q_bit   = (trial >= {1'b0, dsr_q});

  // Sample leaving the window; unwritten entries read as zero
  assign old_sample = rd_vld_q ? rd_q : '0;

  // Frequency test: min_freq * 2 * period > timer clock; a zero period is low unless min_freq is zero
  assign freq_prod = FREQ_W'(minf_q) * FREQ_W'(period_q);
  always_comb begin
    if (period_q == '0) begin
      freq_low = (minf_q != '0);
    end else begin
      freq_low = ((freq_prod << 1) > FREQ_W'(TIMER_CLOCK_HZ));
    end
  end

  // Status: low frequency wins, then thresholds
  always_comb begin
    priority if (low_q) begin
      status = ST_FAIL;
    end else if (avg_q > good_q) begin
      status = ST_GOOD;
    end else if (avg_q < fail_q) begin
      status = ST_FAIL;
    end else begin
      status = ST_INVALID;
    end
  end

  // State updates driven by the control word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      action_q <= '0;
      count_q  <= '0;
      period_q <= '0;
      high_q   <= '0;
      sum_q    <= '0;
      ptr_q    <= '0;
      avg_q    <= '0;
      low_q    <= 1'b0;
      vld_q    <= '0;
      cnt_q    <= '0;
    end else begin
      unique case (uc.op)
        OP_IDLE: begin
          if (in_fire) begin
            action_q <= in_i.action;
            count_q  <= in_i.capture_count;
          end
        end
        OP_UPDATE: begin
          if (action_q == ACT_PERIOD) begin
            period_q <= count_q;
          end else if (action_q == ACT_HIGH) begin
            high_q <= count_q;
          end
        end
        OP_DLOAD_DUTY: begin
          cnt_q <= DCNT_W'(DIV_STEPS);
        end
        OP_DSTEP: begin
          cnt_q <= cnt_q - DCNT_W'(1);
        end
        OP_PUSH: begin
          sum_q        <= sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
          vld_q[ptr_q] <= 1'b1;
          ptr_q        <= (ptr_q == PTR_W'(WINDOW_LENGTH - 1)) ? '0 : ptr_q + PTR_W'(1);
        end
        OP_AVG_SET: begin
          avg_q <= avg_prod_q[AVG_SHIFT +: DUTY_W];
        end
        OP_AVG_CLR: begin
          if (action_q == ACT_TICK) begin
            avg_q <= '0;
          end
        end
        OP_FREQ: begin
          low_q <= freq_low;
        end
        OP_MUL, OP_AVG_MUL, OP_SAMPLE, OP_EMIT, OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath working registers
  always_ff @(posedge clk_i) begin
    unique case (uc.op)
      OP_MUL: begin
        prod_q <= DVD_W'(high_q) * DVD_W'(DUTY_FULL);
      end
      OP_DLOAD_DUTY: begin
        rem_q <= prod_q[DVD_W-1:DUTY_W];
        dvd_q <= prod_q[DUTY_W-1:0];
        dsr_q <= period_q;
      end
      OP_DSTEP: begin
        rem_q <= q_bit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        dvd_q <= {dvd_q[DUTY_W-2:0], q_bit};
      end
      OP_SAMPLE: begin
        // zero period gives zero duty; high above period saturates
        if (period_q == '0) begin
          sample_q <= '0;
        end else if (high_q > period_q) begin
          sample_q <= DUTY_W'(DUTY_FULL);
        end else begin
          sample_q <= dvd_q;
        end
        rd_vld_q <= vld_q[ptr_q];
      end
      OP_AVG_MUL: begin
        // window sum divided by the window length
        avg_prod_q <= AVG_PROD_W'(sum_q) * AVG_PROD_W'(AVG_RECIP);
      end
      default: begin
      end
    endcase
  end

  // Window memory: read the outgoing entry, then overwrite it
  always_ff @(posedge clk_i) begin
    if (uc.op == OP_SAMPLE) begin
      rd_q <= win_mem[ptr_q];
    end
    if (uc.op == OP_PUSH) begin
      win_mem[ptr_q] <= sample_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit_fire) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_stat_q <= status;
      out_avg_q  <= avg_q;
      out_low_q  <= low_q;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.mains_status  = out_stat_q;
  assign out_o.average_duty  = out_avg_q;
  assign out_o.frequency_low = out_low_q;

  // APB configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_q <= GOOD_RESET;
      fail_q <= FAIL_RESET;
      minf_q <= MINF_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_GOOD: good_q <= pwdata[DUTY_W-1:0];
        REG_FAIL: fail_q <= pwdata[DUTY_W-1:0];
        REG_MINF: minf_q <= pwdata[MINF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_GOOD: prdata = DATA_W'(good_q);
      REG_FAIL: prdata = DATA_W'(fail_q);
      REG_MINF: prdata = DATA_W'(minf_q);
      default:  prdata = '0;
    endcase
  end

  // Checks
  a_one_request_at_a_time: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready
  ) else $error("request accepted while one is in progress");

  a_avg_in_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.average_duty <= DUTY_W'(DUTY_FULL))
  ) else $error("average duty above full scale");

  a_ptr_in_window: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    ptr_q < PTR_W'(WINDOW_LENGTH)
  ) else $error("window pointer out of range");

  a_low_means_fail: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.frequency_low) |-> (out_o.mains_status == ST_FAIL)
  ) else $error("low frequency not reported as failure");

endmodule

`default_nettype wire
